@@ hw/rtl/soft_knee_compressor_top_macros.svh @@
// Assertion helpers for the compressor control module.
`ifndef SOFT_KNEE_COMPRESSOR_TOP_MACROS_SVH
`define SOFT_KNEE_COMPRESSOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("compressor assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SKC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("compressor assertion failed");

`endif

@@ hw/rtl/skc_pkg.sv @@
`default_nettype none
package skc_pkg;

  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned ASHIFT      = 32 - SAMPLE_BITS;
  localparam int unsigned CFG_W       = 17;
  localparam int unsigned IDX_W       = 3;

  localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [IDX_W-1:0] REG_RATIO     = 3'd1;
  localparam logic [IDX_W-1:0] REG_KNEE      = 3'd2;
  localparam logic [IDX_W-1:0] REG_ATTACK    = 3'd3;
  localparam logic [IDX_W-1:0] REG_RELEASE   = 3'd4;
  localparam logic [IDX_W-1:0] REG_DETECTOR  = 3'd5;
  localparam logic [IDX_W-1:0] REG_BLEND     = 3'd6;

  typedef struct packed {
    logic signed [14:0] threshold_db;
    logic [12:0]        ratio;
    logic [12:0]        knee_db;
    logic [15:0]        attack_coeff;
    logic [15:0]        release_coeff;
    logic [15:0]        detector_coeff;
    logic [16:0]        blend;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MAGB,
    OP_DETA,
    OP_DETB,
    OP_DETC,
    OP_SMK,
    OP_SMA,
    OP_SMB,
    OP_SMC,
    OP_NINIT,
    OP_NORM,
    OP_LOG,
    OP_DB,
    OP_T2,
    OP_DINIT1,
    OP_DIVSTEP,
    OP_T3,
    OP_DEN,
    OP_NUMA,
    OP_NUMB,
    OP_DINIT2,
    OP_EXPA,
    OP_EXPB,
    OP_WET,
    OP_WET2,
    OP_MULX,
    OP_FIN
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] step;
  } cmd_t;

  function automatic logic [16:0] log2_lut(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0:    v = 17'd0;
      5'd1:    v = 17'd5732;
      5'd2:    v = 17'd11136;
      5'd3:    v = 17'd16248;
      5'd4:    v = 17'd21098;
      5'd5:    v = 17'd25711;
      5'd6:    v = 17'd30109;
      5'd7:    v = 17'd34312;
      5'd8:    v = 17'd38336;
      5'd9:    v = 17'd42196;
      5'd10:   v = 17'd45904;
      5'd11:   v = 17'd49472;
      5'd12:   v = 17'd52911;
      5'd13:   v = 17'd56229;
      5'd14:   v = 17'd59434;
      5'd15:   v = 17'd62534;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

  function automatic logic [16:0] exp2_lut(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/skc_ctrl.sv @@
`default_nettype none
module skc_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output skc_pkg::cmd_t     cmd_o
);
  import skc_pkg::*;
  `include "soft_knee_compressor_top_macros.svh"

  typedef enum logic [4:0] {
    ST_IDLE, ST_MAGB, ST_DETA, ST_DETB, ST_DETC, ST_SMK, ST_SMA, ST_SMB, ST_SMC,
    ST_NINIT, ST_NORM, ST_LOG, ST_DB, ST_T2, ST_DINIT1, ST_DIV1, ST_T3, ST_DEN,
    ST_NUMA, ST_NUMB, ST_DINIT2, ST_DIV2, ST_EXPA, ST_EXPB, ST_WET, ST_WET2,
    ST_MULX, ST_FIN
  } state_e;

  state_e     state_q;
  logic [3:0] cnt_q;
  logic       out_valid_q;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.step = cnt_q[2:0];
    case (state_q)
      ST_IDLE:   cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      ST_MAGB:   cmd_o.op = OP_MAGB;
      ST_DETA:   cmd_o.op = OP_DETA;
      ST_DETB:   cmd_o.op = OP_DETB;
      ST_DETC:   cmd_o.op = OP_DETC;
      ST_SMK:    cmd_o.op = OP_SMK;
      ST_SMA:    cmd_o.op = OP_SMA;
      ST_SMB:    cmd_o.op = OP_SMB;
      ST_SMC:    cmd_o.op = OP_SMC;
      ST_NINIT:  cmd_o.op = OP_NINIT;
      ST_NORM:   cmd_o.op = OP_NORM;
      ST_LOG:    cmd_o.op = OP_LOG;
      ST_DB:     cmd_o.op = OP_DB;
      ST_T2:     cmd_o.op = OP_T2;
      ST_DINIT1: cmd_o.op = OP_DINIT1;
      ST_DIV1:   cmd_o.op = OP_DIVSTEP;
      ST_T3:     cmd_o.op = OP_T3;
      ST_DEN:    cmd_o.op = OP_DEN;
      ST_NUMA:   cmd_o.op = OP_NUMA;
      ST_NUMB:   cmd_o.op = OP_NUMB;
      ST_DINIT2: cmd_o.op = OP_DINIT2;
      ST_DIV2:   cmd_o.op = OP_DIVSTEP;
      ST_EXPA:   cmd_o.op = OP_EXPA;
      ST_EXPB:   cmd_o.op = OP_EXPB;
      ST_WET:    cmd_o.op = OP_WET;
      ST_WET2:   cmd_o.op = OP_WET2;
      ST_MULX:   cmd_o.op = OP_MULX;
      ST_FIN:    cmd_o.op = out_free ? OP_FIN : OP_NONE;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_MAGB;
          end
        end
        ST_MAGB:  state_q <= ST_DETA;
        ST_DETA:  state_q <= ST_DETB;
        ST_DETB:  state_q <= ST_DETC;
        ST_DETC:  state_q <= ST_SMK;
        ST_SMK:   state_q <= ST_SMA;
        ST_SMA:   state_q <= ST_SMB;
        ST_SMB:   state_q <= ST_SMC;
        ST_SMC:   state_q <= ST_NINIT;
        ST_NINIT: begin
          cnt_q   <= '0;
          state_q <= ST_NORM;
        end
        ST_NORM: begin
          if (cnt_q == 4'd4) begin
            cnt_q   <= '0;
            state_q <= ST_LOG;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        ST_LOG:    state_q <= ST_DB;
        ST_DB:     state_q <= ST_T2;
        ST_T2:     state_q <= ST_DINIT1;
        ST_DINIT1: state_q <= ST_DIV1;
        ST_DIV1: begin
          if (cnt_q == 4'd15) begin
            cnt_q   <= '0;
            state_q <= ST_T3;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        ST_T3:     state_q <= ST_DEN;
        ST_DEN:    state_q <= ST_NUMA;
        ST_NUMA:   state_q <= ST_NUMB;
        ST_NUMB:   state_q <= ST_DINIT2;
        ST_DINIT2: state_q <= ST_DIV2;
        ST_DIV2: begin
          if (cnt_q == 4'd14) begin
            cnt_q   <= '0;
            state_q <= ST_EXPA;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        ST_EXPA: state_q <= ST_EXPB;
        ST_EXPB: state_q <= ST_WET;
        ST_WET:  state_q <= ST_WET2;
        ST_WET2: state_q <= ST_MULX;
        ST_MULX: state_q <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `SKC_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o, state_q == ST_MAGB)
  `SKC_ASSERT_NEXT(a_fin_delivers, state_q == ST_FIN && out_free, out_valid_o && in_ready_o)
  `SKC_ASSERT_SAME(a_idle_count_clear, in_ready_o, cnt_q == 4'd0)

endmodule
`default_nettype wire

@@ hw/rtl/skc_datapath.sv @@
`default_nettype none
module skc_datapath (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  skc_pkg::cmd_t                         cmd_i,
  input  skc_pkg::cfg_t                         cfg_i,
  input  wire signed [skc_pkg::SAMPLE_BITS-1:0] sample_in_i,
  output logic signed [skc_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic [15:0]                           gain_reduction_o
);
  import skc_pkg::*;

  localparam int unsigned SB = SAMPLE_BITS;
  localparam logic signed [SB:0] YMAX = (SB+1)'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic signed [SB:0] YMIN = -(SB+1)'(64'd1 << (SB - 1));

  logic signed [SB-1:0] x_q, x_d;
  logic [49:0]          p_q, p_d, acc_q, acc_d;
  logic [31:0]          a_q, a_d, det_q, det_d, sm_q, sm_d, norm_q, norm_d;
  logic [15:0]          k_q, k_d, q_q, q_d;
  logic [4:0]           sh_q, sh_d;
  logic [16:0]          frac_q, frac_d, t3_q, t3_d, g_q, g_d, wet_q, wet_d;
  logic [14:0]          t2_q, t2_d;
  logic [47:0]          rem_q, rem_d, dsh_q, dsh_d;
  logic                 ovr_q, ovr_d, sat_q, sat_d;
  logic [30:0]          den_q, den_d;
  logic [21:0]          ea_q, ea_d;
  logic signed [SB-1:0] yo_q, yo_d;
  logic [15:0]          gr_q, gr_d;

  logic [16:0]          b;
  logic [SB-1:0]        mag;
  logic signed [14:0]   s;
  logic [5:0]           w;
  logic [32:0]          ltmp;
  logic [16:0]          l0, l1, e0, e1, ev;
  logic [20:0]          neg;
  logic [15:0]          dbmag, e;
  logic signed [17:0]   tt;
  logic signed [32:0]   dtmp;
  logic signed [47:0]   num;
  logic [47:0]          nmag;
  logic [28:0]          etmp;
  logic [49:0]          wsum;
  logic signed [SB:0]   y;

  assign b   = (cfg_i.blend > 17'd65536) ? 17'd65536 : cfg_i.blend;
  assign mag = x_q[SB-1] ? SB'(-x_q) : SB'(x_q);
  assign s   = 15'sd256 - $signed({2'b00, cfg_i.ratio});

  always_comb begin
    x_d = x_q; p_d = p_q; acc_d = acc_q; a_d = a_q; det_d = det_q; sm_d = sm_q;
    norm_d = norm_q; k_d = k_q; q_d = q_q; sh_d = sh_q; frac_d = frac_q;
    t3_d = t3_q; g_d = g_q; wet_d = wet_q; t2_d = t2_q; rem_d = rem_q;
    dsh_d = dsh_q; ovr_d = ovr_q; sat_d = sat_q; den_d = den_q; ea_d = ea_q;
    yo_d = yo_q; gr_d = gr_q;
    w     = 6'd16 >> cmd_i.step;
    l0    = log2_lut({1'b0, norm_q[30:27]});
    l1    = log2_lut(5'({1'b0, norm_q[30:27]} + 5'd1));
    ltmp  = 33'(l1 - l0) * 33'(norm_q[26:11]);
    neg   = {sh_q, 16'd0} - {4'd0, frac_q};
    dbmag = p_q[39:24];
    tt    = $signed(18'({5'd0, cfg_i.knee_db})) - $signed(18'({2'd0, dbmag}))
            - 18'(cfg_i.threshold_db);
    dtmp  = 33'sd16777216 - 33'($signed(p_q[31:0]));
    num   = $signed(p_q[47:0]);
    nmag  = num[47] ? 48'(-num) : 48'd0;
    e     = sat_q ? 16'd32768 : q_q;
    e0    = exp2_lut({1'b0, ea_q[15:12]});
    e1    = exp2_lut(5'({1'b0, ea_q[15:12]} + 5'd1));
    etmp  = 29'(e0 - e1) * 29'(ea_q[11:0]);
    ev    = e0 - 17'(etmp >> 12);
    wsum  = (50'(17'd65536 - b) << 16) + p_q;
    y     = $signed(p_q[SB+16:16]);
    case (cmd_i.op)
      OP_LOAD: x_d = sample_in_i;
      OP_MAGB: p_d = 50'(mag) * 50'(b);
      OP_DETA: begin
        a_d = 32'(p_q >> 16) << ASHIFT;
        p_d = 50'(cfg_i.detector_coeff) * 50'(det_q);
      end
      OP_DETB: begin
        acc_d = p_q;
        p_d   = 50'(17'd65536 - {1'b0, cfg_i.detector_coeff}) * 50'(a_q);
      end
      OP_DETC: det_d = 32'((acc_q + p_q) >> 16);
      OP_SMK:  k_d = (sm_q < det_q) ? cfg_i.attack_coeff : cfg_i.release_coeff;
      OP_SMA:  acc_d = 50'(k_q) * 50'(sm_q);
      OP_SMB:  p_d = 50'(17'd65536 - {1'b0, k_q}) * 50'(det_q);
      OP_SMC:  sm_d = 32'((acc_q + p_q) >> 16);
      OP_NINIT: begin
        norm_d = (sm_q == 32'd0) ? 32'd1 : sm_q;
        sh_d   = 5'd0;
      end
      OP_NORM: begin
        if ((norm_q >> (6'd32 - w)) == 32'd0) begin
          norm_d = norm_q << w;
          sh_d   = sh_q + 5'(w);
        end
      end
      OP_LOG: frac_d = l0 + 17'(ltmp >> 16);
      OP_DB:  p_d = 50'(neg) * 50'(19'd394566);
      OP_T2:  t2_d = tt[17] ? 15'd0 : tt[14:0];
      OP_DINIT1: begin
        rem_d = 48'({t2_q, 16'd0});
        dsh_d = 48'({cfg_i.knee_db, 15'd0});
        q_d   = 16'd0;
        ovr_d = ({2'b00, t2_q} >= {4'd0, cfg_i.knee_db});
      end
      OP_DIVSTEP: begin
        if (rem_q >= dsh_q) begin
          rem_d = rem_q - dsh_q;
          q_d   = {q_q[14:0], 1'b1};
        end else begin
          q_d = {q_q[14:0], 1'b0};
        end
        dsh_d = dsh_q >> 1;
      end
      OP_T3: t3_d = ovr_q ? ((t2_q == 15'd0) ? 17'd0 : 17'd65536) : {1'b0, q_q};
      OP_DEN: p_d = 50'(s) * 50'($signed({1'b0, t3_q}));
      OP_NUMA: begin
        den_d = (dtmp < 33'sd1) ? 31'd1 : dtmp[30:0];
        p_d   = 50'(s) * 50'($signed({1'b0, t2_q}));
      end
      OP_NUMB: p_d = 50'($signed(p_q[29:0])) * 50'($signed({1'b0, t3_q}));
      OP_DINIT2: begin
        rem_d = nmag;
        dsh_d = 48'(den_q) << 14;
        sat_d = nmag >= (48'(den_q) << 15);
        q_d   = 16'd0;
      end
      OP_EXPA: ea_d = 22'((30'(e) * 30'(14'd10885)) >> 8);
      OP_EXPB: g_d = (ea_q[21:16] > 6'd16) ? 17'd0 : (ev >> ea_q[20:16]);
      OP_WET:  p_d = 50'(b) * 50'(g_q);
      OP_WET2: wet_d = 17'(wsum >> 16);
      OP_MULX: p_d = 50'(x_q) * 50'($signed({1'b0, wet_q}));
      OP_FIN: begin
        if (y > YMAX) begin
          yo_d = YMAX[SB-1:0];
        end else if (y < YMIN) begin
          yo_d = YMIN[SB-1:0];
        end else begin
          yo_d = y[SB-1:0];
        end
        gr_d = (g_q == 17'd0) ? 16'hFFFF : 16'(17'd65536 - g_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_q <= '0;
      sm_q  <= '0;
    end else begin
      det_q <= det_d;
      sm_q  <= sm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; p_q <= p_d; acc_q <= acc_d; a_q <= a_d; norm_q <= norm_d;
    k_q <= k_d; q_q <= q_d; sh_q <= sh_d; frac_q <= frac_d; t3_q <= t3_d;
    g_q <= g_d; wet_q <= wet_d; t2_q <= t2_d; rem_q <= rem_d; dsh_q <= dsh_d;
    ovr_q <= ovr_d; sat_q <= sat_d; den_q <= den_d; ea_q <= ea_d;
    yo_q <= yo_d; gr_q <= gr_d;
  end

  assign sample_out_o     = yo_q;
  assign gain_reduction_o = gr_q;

endmodule
`default_nettype wire

@@ hw/rtl/soft_knee_compressor_top.sv @@
`default_nettype none
// Feed-forward soft-knee compressor for Q1.23 audio. A sample is taken when
// in_valid_i and in_ready_o are both high; the compressed sample and its
// gain reduction appear one at a time on the output channel, held in an
// output register so that the next sample may be taken while the last result
// waits. Each sample occupies the shared datapath from acceptance until the
// block is ready again, most of that time spent in the bit-per-cycle divider,
// which runs sixteen steps for the knee fraction and fifteen for the gain in
// dB; the level-to-dB normalisation adds five more. The user must write the
// registers through cfg_we_i while the block is idle; it does not enforce this.
module soft_knee_compressor_top (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    cfg_we_i,
  input  wire [skc_pkg::IDX_W-1:0]               cfg_index_i,
  input  wire [skc_pkg::CFG_W-1:0]               cfg_wdata_i,
  input  wire                                    in_valid_i,
  output logic                                   in_ready_o,
  input  wire signed [skc_pkg::SAMPLE_BITS-1:0]  sample_in_i,
  output logic                                   out_valid_o,
  input  wire                                    out_ready_i,
  output logic signed [skc_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic [15:0]                            gain_reduction_o
);
  import skc_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold_db   <= -15'sd5120;
      cfg_q.ratio          <= 13'd512;
      cfg_q.knee_db        <= 13'd768;
      cfg_q.attack_coeff   <= 16'd63145;
      cfg_q.release_coeff  <= 16'd65467;
      cfg_q.detector_coeff <= 16'd65522;
      cfg_q.blend          <= 17'd65536;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_THRESHOLD: cfg_q.threshold_db   <= $signed(cfg_wdata_i[14:0]);
        REG_RATIO:     cfg_q.ratio          <= cfg_wdata_i[12:0];
        REG_KNEE:      cfg_q.knee_db        <= cfg_wdata_i[12:0];
        REG_ATTACK:    cfg_q.attack_coeff   <= cfg_wdata_i[15:0];
        REG_RELEASE:   cfg_q.release_coeff  <= cfg_wdata_i[15:0];
        REG_DETECTOR:  cfg_q.detector_coeff <= cfg_wdata_i[15:0];
        REG_BLEND:     cfg_q.blend          <= cfg_wdata_i[16:0];
        default: ;
      endcase
    end
  end

  skc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  skc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_i            (cfg_q),
    .sample_in_i      (sample_in_i),
    .sample_out_o     (sample_out_o),
    .gain_reduction_o (gain_reduction_o)
  );

endmodule
`default_nettype wire

@@ tb/soft_knee_compressor_top_test.sv @@
`timescale 1ns / 1ps
module soft_knee_compressor_top_test;
  import skc_pkg::*;

  typedef struct {
    logic signed [23:0] sample;
    logic [15:0]        reduction;
  } comp_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [SAMPLE_BITS-1:0] sample_in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_out_o;
  logic [15:0] gain_reduction_o;

  soft_knee_compressor_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .sample_in_i,
    .out_valid_o, .out_ready_i, .sample_out_o, .gain_reduction_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mirror of the block's settings and level state.
  logic signed [14:0] m_threshold;
  logic [12:0] m_ratio, m_knee;
  logic [15:0] m_attack, m_release, m_detector;
  logic [16:0] m_blend;
  logic [31:0] det_level, smooth_level;

  comp_result_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_count = 0;

  localparam longint LOG2_TAB[17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109,
    34312, 38336, 42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};
  localparam longint EXP2_TAB[17] = '{65536, 62757, 60097, 57549, 55109, 52773,
    50535, 48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

  function automatic longint level_to_db(logic [31:0] lvl);
    int p;
    logic [31:0] m;
    longint idx, rem, frac, neg;
    if (lvl == 0) lvl = 1;
    p = 31;
    while (p > 0 && !lvl[p]) p--;
    m = lvl << (31 - p);
    idx = m[30:27];
    rem = m[26:11];
    frac = LOG2_TAB[idx] + (((LOG2_TAB[idx+1] - LOG2_TAB[idx]) * rem) >>> 16);
    neg = longint'(31 - p) * 65536 - frac;
    return -((neg * 394566) >>> 24);
  endfunction

  function automatic longint db_to_linear(longint gdb);
    longint a, n, f, idx, rem, v;
    a = ((-gdb) * 10885) >>> 8;
    n = a >>> 16;
    f = a & 16'hFFFF;
    idx = f >>> 12;
    rem = f & 12'hFFF;
    if (n > 16) return 0;
    v = EXP2_TAB[idx] - (((EXP2_TAB[idx] - EXP2_TAB[idx+1]) * rem) >>> 12);
    return v >>> n;
  endfunction

  function automatic comp_result_t compress_sample(logic signed [23:0] x_in);
    comp_result_t r;
    longint x, b, mag, a, k, wet, db, t2, t3, s, den, num, gdb, y, g, p;
    x = x_in;
    b = (m_blend > 17'd65536) ? 65536 : m_blend;
    mag = x < 0 ? -x : x;
    a = ((mag * b) >>> 16) << (32 - SAMPLE_BITS);
    det_level = 32'((longint'(m_detector) * det_level + (65536 - m_detector) * a) >>> 16);
    k = (smooth_level < det_level) ? m_attack : m_release;
    smooth_level = 32'((k * smooth_level + (65536 - k) * det_level) >>> 16);
    db = level_to_db(smooth_level);
    t2 = longint'(m_knee) + db - longint'(m_threshold);
    if (t2 < 0) t2 = 0;
    if (m_knee == 0) t3 = t2 > 0 ? 65536 : 0;
    else begin
      t3 = (t2 << 16) / m_knee;
      if (t3 > 65536) t3 = 65536;
    end
    s = 256 - longint'(m_ratio);
    den = (longint'(1) << 24) - s * t3;
    if (den < 1) den = 1;
    num = s * t2 * t3;
    gdb = num / den;
    if (gdb > 0) gdb = 0;
    if (gdb < -32768) gdb = -32768;
    g = db_to_linear(gdb);
    wet = ((65536 - b) * 65536 + b * g) >>> 16;
    p = x * wet;
    y = (p >= 0) ? (p >>> 16) : -((-p + 65535) >>> 16);
    if (y > 8388607) y = 8388607;
    if (y < -8388608) y = -8388608;
    r.sample = 24'(y);
    r.reduction = (g == 0) ? 16'hFFFF : 16'(65536 - g);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_THRESHOLD: m_threshold = val[14:0];
      REG_RATIO:     m_ratio = val[12:0];
      REG_KNEE:      m_knee = val[12:0];
      REG_ATTACK:    m_attack = val[15:0];
      REG_RELEASE:   m_release = val[15:0];
      REG_DETECTOR:  m_detector = val[15:0];
      REG_BLEND:     m_blend = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_sample(logic signed [23:0] x);
    if (gap_left > 0) begin
      in_valid_i <= 1'b0;
      while (gap_left > 0) begin
        gap_left--;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    sample_in_i <= x;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(compress_sample(x));
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 12);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic signed [23:0] random_sample();
    case ($urandom_range(0, 5))
      0: return 24'($urandom_range(0, 255)) - 24'sd128;
      1: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic test_directed();
    logic signed [23:0] vals[12];
    vals = '{24'sh0, 24'sh7FFFFF, 24'sh800000, 24'sh1, -24'sh1, 24'sh400000,
             -24'sh400000, 24'sh555555, 24'shAAAAAA, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh0};
    foreach (vals[i]) send_sample(vals[i]);
    wait_drained();
    // Hard knee, ratio below one and a blend above one.
    write_reg(REG_KNEE, 17'd0);
    write_reg(REG_RATIO, 17'd0);
    write_reg(REG_BLEND, 17'h1FFFF);
    write_reg(REG_THRESHOLD, 17'h0);
    for (int i = 0; i < 6; i++) send_sample(i[0] ? 24'sh7FFFFF : 24'sh800000);
    wait_drained();
    // Steep ratio with fast attack and detector poles drives a deep gain cut.
    write_reg(REG_RATIO, 17'd8191);
    write_reg(REG_THRESHOLD, 17'h4000);
    write_reg(REG_ATTACK, 17'd0);
    write_reg(REG_DETECTOR, 17'd0);
    write_reg(REG_RELEASE, 17'd65535);
    for (int i = 0; i < 6; i++) send_sample(24'sh7FFFFF);
    wait_drained();
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 20; phase++) begin
      write_reg(REG_THRESHOLD, phase == 0 ? 17'(-10240) : 17'($urandom()));
      write_reg(REG_RATIO, phase == 1 ? 17'd5120 : 17'($urandom_range(0, 8191)));
      write_reg(REG_KNEE, phase == 2 ? 17'd6144 : 17'($urandom_range(0, 8191)));
      write_reg(REG_ATTACK, 17'($urandom_range(0, 65535)));
      write_reg(REG_RELEASE, 17'($urandom_range(0, 65535)));
      write_reg(REG_DETECTOR, phase == 3 ? 17'd65535 : 17'($urandom_range(0, 65535)));
      write_reg(REG_BLEND, phase == 4 ? 17'd0 : 17'($urandom_range(0, 131071)));
      for (int i = 0; i < 76; i++) send_sample(random_sample());
      wait_drained();
    end
  endtask

  always @(posedge clk_i) begin
    comp_result_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("result with no request outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (sample_out_o !== want.sample)
          report_mismatch("sample_out", sample_out_o, want.sample);
        if (gain_reduction_o !== want.reduction)
          report_mismatch("gain_reduction", gain_reduction_o, want.reduction);
      end
    end
    if (stall_count == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_count = $urandom_range(1, 150);
    end else stall_count--;
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= $urandom_range(0, 1);
      default: out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("soft_knee_compressor_top regression: fail");
      $finish;
    end
  end

  initial begin
    m_threshold = -15'sd5120;
    m_ratio = 13'd512;
    m_knee = 13'd768;
    m_attack = 16'd63145;
    m_release = 16'd65467;
    m_detector = 16'd65522;
    m_blend = 17'd65536;
    det_level = '0;
    smooth_level = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_settings();
    if (errors == 0) $display("soft_knee_compressor_top regression: pass");
    else $display("soft_knee_compressor_top regression: fail");
    $finish;
  end
endmodule

@@ soft_knee_compressor_top.f @@
+incdir+hw/rtl
hw/rtl/skc_pkg.sv
hw/rtl/skc_ctrl.sv
hw/rtl/skc_datapath.sv
hw/rtl/soft_knee_compressor_top.sv
tb/soft_knee_compressor_top_test.sv
